[hdl/servo_ascii_command_encoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// servo ascii command encoder - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SERVO_ASCII_COMMAND_ENCODER_UNIT_DEFINES_SVH
`define SERVO_ASCII_COMMAND_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define SACE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sace_pkg.sv]
// ----------------------------------------------------------------------------
// sace_pkg
// widths, characters, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package sace_pkg;

  localparam int CH_W       = 5;
  localparam int VAL_W      = 16;
  localparam int PULSE_W    = 14;
  localparam int PROD_W     = VAL_W + PULSE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 24;
  localparam int CNT_W      = 4;

  // both the divider and the decimal converter run one step per pulse bit
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(PULSE_W - 1);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [PULSE_W-1:0] PULSE_LIMIT = PULSE_W'(9999);

  localparam logic                  ENABLED_RST   = 1'b0;
  localparam logic [VAL_W-1:0]      INPUT_MIN_RST = VAL_W'(0);
  localparam logic [VAL_W-1:0]      INPUT_MAX_RST = VAL_W'(1000);
  localparam logic [PULSE_W-1:0]    PULSE_MIN_RST = PULSE_W'(500);
  localparam logic [PULSE_W-1:0]    PULSE_MAX_RST = PULSE_W'(2500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED,
    REG_INPUT_MIN,
    REG_INPUT_MAX,
    REG_PULSE_MIN,
    REG_PULSE_MAX
  } cfg_reg_t;

  // byte slots of one command string, in emission order
  typedef enum logic [3:0] {
    SLOT_HASH,
    SLOT_CH_TENS,
    SLOT_CH_ONES,
    SLOT_SEP,
    SLOT_P,
    SLOT_D3,
    SLOT_D2,
    SLOT_D1,
    SLOT_D0,
    SLOT_TERM
  } slot_t;

  typedef struct packed {
    logic  take_item;
    logic  mul;
    logic  div_load;
    logic  div_step;
    logic  fix;
    logic  bcd_step;
    logic  load_out;
    slot_t slot;
  } sace_cmd_t;

  typedef struct packed {
    logic enabled;
    logic in_range;
    logic close_open;
    logic skip;
    logic out_free;
  } sace_status_t;

endpackage

[hdl/sace_datapath.sv]
// ----------------------------------------------------------------------------
// sace_datapath
// config registers, item latch, scaling multiply, restoring divider, clamp,
// binary to bcd converter, byte selection and output register
// ----------------------------------------------------------------------------
module sace_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sace_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [sace_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sace_pkg::CFG_DATA_W-1:0] cfg_data,
  input  sace_pkg::sace_cmd_t             cmd,
  output sace_pkg::sace_status_t          status
);
  import sace_pkg::*;

  logic                 enabled;
  logic [VAL_W-1:0]     input_min;
  logic [VAL_W-1:0]     input_max;
  logic [PULSE_W-1:0]   pulse_min;
  logic [PULSE_W-1:0]   pulse_max;
  logic                 group_open;

  logic [CH_W-1:0]      channel;
  logic [VAL_W-1:0]     value;
  logic                 end_group;

  logic                 neg;
  logic                 neg_r;
  logic [PROD_W-1:0]    prod;
  logic [VAL_W-1:0]     rem;
  logic [PULSE_W-1:0]   quot;
  logic [PULSE_W-1:0]   bin;
  logic [15:0]          bcd;

  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_last;

  logic [PULSE_W:0]     diff;
  logic [PULSE_W-1:0]   diff_mag;
  logic [VAL_W:0]       trial;
  logic [VAL_W:0]       trial_sub;
  logic [15:0]          psum;
  logic [PULSE_W-1:0]   pulse_clamped;
  logic [15:0]          bcd_adj;
  logic [1:0]           ch_tens;
  logic [3:0]           ch_ones;
  logic [7:0]           byte_sel;
  logic                 skip;

  function automatic logic [3:0] add3(input logic [3:0] n);
    add3 = (n >= 4'd5) ? n + 4'd3 : n;
  endfunction

  // signed pulse range difference and its magnitude
  always_comb begin
    diff     = {1'b0, pulse_max} - {1'b0, pulse_min};
    neg      = diff[PULSE_W];
    diff_mag = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];
  end

  always_comb begin
    trial     = {rem, quot[PULSE_W-1]};
    trial_sub = trial - {1'b0, input_max};
  end

  always_comb begin
    logic [PULSE_W-1:0] q;
    q = (input_max == '0) ? '0 : quot;
    if (neg_r) psum = {2'b00, pulse_min} - {2'b00, q};
    else       psum = {2'b00, pulse_min} + {2'b00, q};
    if (psum[15])                              pulse_clamped = '0;
    else if (psum > {2'b00, PULSE_LIMIT})      pulse_clamped = PULSE_LIMIT;
    else                                       pulse_clamped = psum[PULSE_W-1:0];
  end

  always_comb begin
    bcd_adj = {add3(bcd[15:12]), add3(bcd[11:8]), add3(bcd[7:4]), add3(bcd[3:0])};
  end

  always_comb begin
    if (channel >= CH_W'(30))      ch_tens = 2'd3;
    else if (channel >= CH_W'(20)) ch_tens = 2'd2;
    else if (channel >= CH_W'(10)) ch_tens = 2'd1;
    else                           ch_tens = 2'd0;
    ch_ones = 4'(channel - CH_W'(ch_tens) * CH_W'(10));
  end

  always_comb begin
    byte_sel = CH_SPACE;
    skip     = 1'b0;
    case (cmd.slot)
      SLOT_HASH:    byte_sel = CH_HASH;
      SLOT_CH_TENS: begin
        byte_sel = CH_ZERO + {6'd0, ch_tens};
        skip     = (ch_tens == 2'd0);
      end
      SLOT_CH_ONES: byte_sel = CH_ZERO + {4'd0, ch_ones};
      SLOT_SEP:     byte_sel = CH_SPACE;
      SLOT_P:       byte_sel = CH_P;
      SLOT_D3: begin
        byte_sel = CH_ZERO + {4'd0, bcd[15:12]};
        skip     = (bcd[15:12] == 4'd0);
      end
      SLOT_D2: begin
        byte_sel = CH_ZERO + {4'd0, bcd[11:8]};
        skip     = (bcd[15:8] == 8'd0);
      end
      SLOT_D1: begin
        byte_sel = CH_ZERO + {4'd0, bcd[7:4]};
        skip     = (bcd[15:4] == 12'd0);
      end
      SLOT_D0:      byte_sel = CH_ZERO + {4'd0, bcd[3:0]};
      SLOT_TERM:    byte_sel = end_group ? CH_CR : CH_SPACE;
      default:      byte_sel = CH_SPACE;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= ENABLED_RST;
      input_min <= INPUT_MIN_RST;
      input_max <= INPUT_MAX_RST;
      pulse_min <= PULSE_MIN_RST;
      pulse_max <= PULSE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:   enabled   <= cfg_data[0];
        REG_INPUT_MIN: input_min <= cfg_data[VAL_W-1:0];
        REG_INPUT_MAX: input_max <= cfg_data[VAL_W-1:0];
        REG_PULSE_MIN: pulse_min <= cfg_data[PULSE_W-1:0];
        REG_PULSE_MAX: pulse_max <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // control state: group flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (cmd.slot == SLOT_TERM) group_open <= ~end_group;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      channel   <= s_axis_tdata[CH_W-1:0];
      value     <= s_axis_tdata[CH_W+VAL_W-1:CH_W];
      end_group <= s_axis_tlast;
    end
    if (cmd.mul) begin
      prod  <= PROD_W'(value) * PROD_W'(diff_mag);
      neg_r <= neg;
    end
    if (cmd.div_load) begin
      rem  <= prod[PROD_W-1:PULSE_W];
      quot <= prod[PULSE_W-1:0];
    end else if (cmd.div_step) begin
      if (!trial_sub[VAL_W]) begin
        rem  <= trial_sub[VAL_W-1:0];
        quot <= {quot[PULSE_W-2:0], 1'b1};
      end else begin
        rem  <= trial[VAL_W-1:0];
        quot <= {quot[PULSE_W-2:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      bin <= pulse_clamped;
      bcd <= '0;
    end else if (cmd.bcd_step) begin
      bcd <= {bcd_adj[14:0], bin[PULSE_W-1]};
      bin <= {bin[PULSE_W-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      out_byte <= byte_sel;
      out_last <= (cmd.slot == SLOT_TERM);
    end
  end

  always_comb begin
    status.enabled    = enabled;
    status.in_range   = (value <= input_max) && (value >= input_min);
    status.close_open = end_group && group_open;
    status.skip       = skip;
    status.out_free   = ~out_valid | m_axis_tready;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;

endmodule

[hdl/sace_ctrl.sv]
// ----------------------------------------------------------------------------
// sace_ctrl
// sequencer: accept, check, multiply, divide, clamp, convert, emit bytes
// ----------------------------------------------------------------------------
`include "servo_ascii_command_encoder_unit_defines.svh"

module sace_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  sace_pkg::sace_status_t status,
  output sace_pkg::sace_cmd_t    cmd
);
  import sace_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_DIV,
    S_FIX,
    S_BCD,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  slot_t            slot;

  always_comb begin
    cmd           = '0;
    cmd.slot      = slot;
    s_axis_tready = (state == S_IDLE);
    case (state)
      S_IDLE:  cmd.take_item = s_axis_tvalid;
      S_CHECK: cmd.mul       = status.enabled & status.in_range;
      S_LOAD:  cmd.div_load  = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_FIX:   cmd.fix       = 1'b1;
      S_BCD:   cmd.bcd_step  = 1'b1;
      S_EMIT:  cmd.load_out  = ~status.skip & status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      slot  <= SLOT_HASH;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (!status.enabled) begin
            state <= S_IDLE;
          end else if (!status.in_range) begin
            if (status.close_open) begin
              slot  <= SLOT_TERM;
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == STEP_LAST) state <= S_FIX;
        end
        S_FIX: begin
          cnt   <= '0;
          state <= S_BCD;
        end
        S_BCD: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == STEP_LAST) begin
            slot  <= SLOT_HASH;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (status.skip) begin
            slot <= slot_t'(slot + 4'd1);
          end else if (status.out_free) begin
            if (slot == SLOT_TERM) state <= S_IDLE;
            else                   slot  <= slot_t'(slot + 4'd1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SACE_ASSERT_NOW(a_load_free, cmd.load_out, status.out_free, "byte loaded into a full output")
  `SACE_ASSERT_NEXT(a_accept_check, s_axis_tvalid && s_axis_tready, state == S_CHECK, "accept did not start a check")
  `SACE_ASSERT_NEXT(a_term_done, cmd.load_out && slot == SLOT_TERM, state == S_IDLE, "terminator did not end the item")
  `SACE_ASSERT_NOW(a_cnt_range, state == S_DIV || state == S_BCD, cnt <= STEP_LAST, "step counter overran")

endmodule

[hdl/servo_ascii_command_encoder_unit.sv]
// ----------------------------------------------------------------------------
// servo_ascii_command_encoder_unit
// turns (channel, position) items into ascii servo commands "#<ch> P<pulse>"
// followed by cr at the end of a group or a space otherwise
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tdata: channel[4:0], value[20:5]; tlast: end_group
// m_axis    out  tdata: out_byte[7:0]; tlast: last_byte
// cfg       in   cfg_index 0..4: enabled, input_min, input_max, pulse_min, pulse_max
//
// one item at a time: accept, check and multiply, load, divide in 14 steps, clamp,
// decimal convert in 14 steps, then walk the byte slots (6 to 10 beats, a skipped
// leading zero still takes its own step through the slots).
// out-of-range or disabled items go back to idle after the check, an out-of-range
// one first emitting a lone cr when it closes an open group.
// rst is synchronous; m_axis_tready low holds the current slot and delays the next accept.
// ----------------------------------------------------------------------------
module servo_ascii_command_encoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sace_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // channel, value
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // out_byte
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [sace_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sace_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sace_pkg::*;

  sace_cmd_t    cmd;
  sace_status_t status;

  sace_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  sace_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

[tb/servo_ascii_command_encoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_ascii_command_encoder_unit_tb
// streams (channel, position) beats into the encoder and checks every emitted
// ascii byte and its last flag against a behavioral encoder kept in the bench;
// register settings change only while the block is idle, both sides stall
// at random
// ----------------------------------------------------------------------------
module servo_ascii_command_encoder_unit_tb;
  import sace_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int ITEM_TARGET   = 380;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } cmd_char_t;

  class command_text_checker;
    logic               enabled;
    logic [VAL_W-1:0]   input_min;
    logic [VAL_W-1:0]   input_max;
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    logic               group_open;
    cmd_char_t          expected_chars[$];
    int                 errors;

    function new();
      enabled    = ENABLED_RST;
      input_min  = INPUT_MIN_RST;
      input_max  = INPUT_MAX_RST;
      pulse_min  = PULSE_MIN_RST;
      pulse_max  = PULSE_MAX_RST;
      group_open = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLED:   enabled   = data[0];
        REG_INPUT_MIN: input_min = data[VAL_W-1:0];
        REG_INPUT_MAX: input_max = data[VAL_W-1:0];
        REG_PULSE_MIN: pulse_min = data[PULSE_W-1:0];
        REG_PULSE_MAX: pulse_max = data[PULSE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_char(logic [7:0] code, logic last);
      cmd_char_t e;
      e.char_code = code;
      e.last      = last;
      expected_chars.push_back(e);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // encode one accepted position beat into its expected command text
    function void take_position(logic [CH_W-1:0] channel, logic [VAL_W-1:0] value,
                                logic end_group);
      longint      pos;
      longint      span;
      longint      base;
      longint      divisor;
      longint      pulse;
      int unsigned width;
      int unsigned div;
      logic        started;
      if (!enabled) return;
      if (value > input_max || value < input_min) begin
        if (end_group && group_open) begin
          push_char(CH_CR, 1'b1);
          group_open = 1'b0;
        end
        return;
      end
      pos     = longint'(value);
      base    = longint'(pulse_min);
      span    = longint'(pulse_max);
      span    = span - base;
      divisor = longint'(input_max);
      pulse   = (divisor != 0) ? (pos * span) / divisor : 0;
      pulse   = pulse + base;
      if (pulse < 0) pulse = 0;
      if (pulse > 9999) pulse = 9999;
      width = int'(pulse);

      push_char(CH_HASH, 1'b0);
      if (channel >= 10) push_char(CH_ZERO + 8'(channel / 10), 1'b0);
      push_char(CH_ZERO + 8'(channel % 10), 1'b0);
      push_char(CH_SPACE, 1'b0);
      push_char(CH_P, 1'b0);
      started = 1'b0;
      for (div = 1000; div > 0; div = div / 10) begin
        if ((width / div) % 10 != 0 || started || div == 1) begin
          push_char(CH_ZERO + 8'((width / div) % 10), 1'b0);
          started = 1'b1;
        end
      end
      push_char(end_group ? CH_CR : CH_SPACE, 1'b1);
      group_open = !end_group;
    endfunction

    function void check_char(logic [7:0] code, logic last);
      cmd_char_t e;
      if (expected_chars.size() == 0) begin
        $error("out_byte %h arrived with no command pending", code);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      if (code !== e.char_code) begin
        $error("out_byte mismatch: expected %h actual %h", e.char_code, code);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_byte mismatch: expected %b actual %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;   // channel[4:0], value[20:5]
  logic                  s_axis_tlast  = 1'b0; // end_group
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;         // out_byte
  logic                  m_axis_tlast;         // last_byte
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  steady_flow = 1'b0;
  int                    hold_cnt    = 0;
  int                    stall_draw;

  command_text_checker   chk = new();

  servo_ascii_command_encoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // byte sink with random stalls per beat
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      chk.check_char(m_axis_tdata, m_axis_tlast);
      stall_draw = steady_flow ? 0 : $urandom_range(0, 15);
      m_axis_tready <= (stall_draw == 0);
      hold_cnt      <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (!m_axis_tready) begin
      if (hold_cnt == 0) m_axis_tready <= 1'b1;
      else hold_cnt <= hold_cnt - 1;
    end
  end

  task automatic send_position(logic [CH_W-1:0] channel, logic [VAL_W-1:0] value,
                               logic end_group);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({value, channel});
    s_axis_tlast  <= end_group;
    do @(posedge clk); while (!s_axis_tready);
    chk.take_position(channel, value, end_group);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    chk.write_reg(idx, data);
  endtask

  task automatic program_regs(logic en, logic [VAL_W-1:0] imin, logic [VAL_W-1:0] imax,
                              logic [PULSE_W-1:0] pmin, logic [PULSE_W-1:0] pmax);
    write_reg(REG_ENABLED, CFG_DATA_W'(en));
    write_reg(REG_INPUT_MIN, imin);
    write_reg(REG_INPUT_MAX, imax);
    write_reg(REG_PULSE_MIN, CFG_DATA_W'(pmin));
    write_reg(REG_PULSE_MAX, CFG_DATA_W'(pmax));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait for every pending byte, then let skipped items finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                 taken;
    int                 phase_len;
    int                 kind;
    logic               en;
    logic [VAL_W-1:0]   lo;
    logic [VAL_W-1:0]   hi;
    logic [VAL_W-1:0]   val;
    logic [PULSE_W-1:0] pmin;
    logic [PULSE_W-1:0] pmax;

    taken = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled out of reset
    send_position(5'd3, 16'd700, 1'b1);
    send_position(5'd12, 16'd20, 1'b0);
    drain();

    // reset scaling
    program_regs(1'b1, INPUT_MIN_RST, INPUT_MAX_RST, PULSE_MIN_RST, PULSE_MAX_RST);
    send_position(5'd0, 16'd0, 1'b1);
    send_position(5'd31, 16'd1000, 1'b0);
    send_position(5'd9, 16'd500, 1'b0);
    send_position(5'd10, 16'd1001, 1'b1);
    send_position(5'd5, 16'd65535, 1'b1);
    send_position(5'd7, 16'd1, 1'b1);
    drain();

    // full input and pulse range, back to back
    steady_flow = 1'b1;
    program_regs(1'b1, 16'd0, 16'd65535, 14'd0, 14'd9999);
    send_position(5'd31, 16'd0, 1'b0);
    send_position(5'd30, 16'd65535, 1'b0);
    send_position(5'd11, 16'd6554, 1'b0);
    send_position(5'd19, 16'd656, 1'b0);
    send_position(5'd2, 16'd1, 1'b1);
    drain();
    steady_flow = 1'b0;

    // zero divisor
    program_regs(1'b1, 16'd0, 16'd0, 14'd1234, 14'd9999);
    send_position(5'd4, 16'd0, 1'b0);
    send_position(5'd4, 16'd1, 1'b1);
    send_position(5'd4, 16'd1, 1'b1);
    drain();

    // reversed pulse bounds
    program_regs(1'b1, 16'd100, 16'd200, 14'd9999, 14'd0);
    send_position(5'd20, 16'd100, 1'b0);
    send_position(5'd21, 16'd200, 1'b0);
    send_position(5'd22, 16'd150, 1'b0);
    send_position(5'd23, 16'd99, 1'b1);
    drain();

    // disabled again mid-run
    program_regs(1'b0, 16'd100, 16'd200, 14'd9999, 14'd0);
    send_position(5'd1, 16'd150, 1'b1);
    drain();

    while (taken < ITEM_TARGET) begin
      kind = $urandom_range(0, 5);
      pmin = PULSE_W'($urandom_range(0, 9999));
      pmax = PULSE_W'($urandom_range(0, 9999));
      case (kind)
        0: begin
          lo = 16'd0;
          hi = 16'hFFFF;
        end
        1: begin
          lo = VAL_W'($urandom_range(0, 65535));
          hi = VAL_W'($urandom_range(0, 65535));
        end
        2: begin
          lo = VAL_W'($urandom_range(0, 65000));
          hi = lo + 16'($urandom_range(0, 20));
        end
        3: begin
          lo = 16'd0;
          hi = 16'd0;
        end
        4: begin
          lo = VAL_W'($urandom_range(0, 30000));
          hi = lo + 16'($urandom_range(1, 30000));
          pmin = PULSE_W'($urandom_range(5000, 9999));
          pmax = PULSE_W'($urandom_range(0, 4999));
        end
        default: begin
          lo = VAL_W'($urandom_range(30001, 65535));
          hi = VAL_W'($urandom_range(0, 30000));
        end
      endcase
      en = ($urandom_range(0, 7) != 0);
      steady_flow = ($urandom_range(0, 3) == 0);
      program_regs(en, lo, hi, pmin, pmax);
      phase_len = (kind == 5) ? $urandom_range(5, 15) : $urandom_range(20, 50);
      for (int i = 0; i < phase_len; i++) begin
        if (lo <= hi && $urandom_range(0, 9) < 8) begin
          val = VAL_W'($urandom_range(hi, lo));
        end else begin
          case ($urandom_range(0, 3))
            0: val = VAL_W'($urandom_range(0, 65535));
            1: val = lo - 16'd1;
            2: val = hi + 16'd1;
            default: val = 16'hFFFF;
          endcase
        end
        send_position(CH_W'($urandom_range(0, 31)), val, ($urandom_range(0, 3) == 0));
        taken++;
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    drain();
    if (chk.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
